@@ rtl/core/slb_pkg.sv @@
package slb_pkg;

   // Frame layout
   localparam int MAX_FRAME_DEFAULT = 50;
   localparam logic [7:0] START_BYTE = 8'h02;
   localparam logic [7:0] TYPE_LIGHT = 8'h01;
   localparam logic [2:0] CLASS_MASK = 3'h7;
   localparam int LEN_OVERHEAD = 3;
   localparam int POS_TYPE = 7;
   localparam int POS_CLASS = 10;
   localparam int POS_LIGHT = 16;

   // Threshold registers
   localparam int NUM_THRESH = 6;
   localparam int THRESH_W = 7;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESH_ONE   = 3'd0,
      CSR_THRESH_TWO   = 3'd1,
      CSR_THRESH_THREE = 3'd2,
      CSR_THRESH_FOUR  = 3'd3,
      CSR_THRESH_FIVE  = 3'd4,
      CSR_THRESH_SIX   = 3'd5
   } csr_index_type;

   typedef logic [THRESH_W-1:0] thresh_array_type [NUM_THRESH];

   localparam logic [THRESH_W-1:0] THRESH_RESET [NUM_THRESH] = '{
      7'd45, 7'd50, 7'd55, 7'd65, 7'd80, 7'd95
   };

   // Parser phase
   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   // Queue between parser and grader
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       type_light;
      logic       class_ok;
      logic [7:0] light;
   } frame_event_type;

   // Config write travelling to the grader
   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [THRESH_W-1:0]    data;
   } csr_write_type;

   // Bar pattern per level
   function automatic logic [5:0] bar_mask(input logic [2:0] level);
      logic [5:0] m;
      unique case (level)
         3'd1: m = 6'h3F;
         3'd2: m = 6'h1F;
         3'd3: m = 6'h0F;
         3'd4: m = 6'h07;
         3'd5: m = 6'h03;
         3'd6: m = 6'h01;
         default: m = 6'h00;
      endcase
      return m;
   endfunction

endpackage

@@ rtl/core/slb_if.sv @@
interface slb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface slb_rsp_if;
   logic              valid;
   logic              ready;
   logic [5:0]        led_mask;
   logic [2:0]        light_level;
   logic signed [7:0] light_reading;

   modport source (output valid, output led_mask, output light_level,
                   output light_reading, input ready);
   modport sink (input valid, input led_mask, input light_level,
                 input light_reading, output ready);
endinterface

@@ rtl/core/sensor_frame_light_bargraph_top.sv @@
// Channel | Dir | Payload                                    | Handshake
// req_ch  | in  | rx_byte[7:0]                               | valid/ready
// rsp_ch  | out | led_mask[5:0], light_level[2:0],           | valid/ready
//         |     | light_reading[7:0] signed                  |
// csr     | in  | csr_index[2:0], csr_wdata[6:0]             | csr_we
//
// One byte per cycle is accepted while the event queue is not full; a frame end
// is queued at the edge that accepts its last byte and graded into the output
// register when the grader pops it from the queue.
// The parser stalls only when its 4-entry event queue is full; the grader
// stalls only while the output register holds a result not yet taken.
// Reset is synchronous and restores thresholds 45/50/55/65/80/95, level 0.
module sensor_frame_light_bargraph_top #(
   parameter int MAX_FRAME = slb_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   slb_req_if.sink                         req_ch,
   slb_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [slb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slb_pkg::THRESH_W-1:0]    csr_wdata
);
   import slb_pkg::*;

   logic            push;
   frame_event_type push_event;
   logic            q_full;
   logic            pop;
   logic            q_valid;
   frame_event_type q_event;
   csr_write_type   csr_wr;

   assign csr_wr.we = csr_we;
   assign csr_wr.index = csr_index;
   assign csr_wr.data = csr_wdata;

   slb_front #(.MAX_FRAME(MAX_FRAME)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_full     (q_full),
      .push       (push),
      .push_event (push_event)
   );

   slb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_event    (q_event)
   );

   slb_back u_back (
      .clock   (clock),
      .reset   (reset),
      .csr_wr  (csr_wr),
      .q_valid (q_valid),
      .q_event (q_event),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

@@ rtl/core/slb_front.sv @@
module slb_front #(
   parameter int MAX_FRAME = slb_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   slb_req_if.sink                  req_ch,
   input  logic                     q_full,
   output logic                     push,
   output slb_pkg::frame_event_type push_event
);
   import slb_pkg::*;

   localparam int IDX_W = $clog2(MAX_FRAME + 1);

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] total_ff, total_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       class_ff, class_in;
   logic [7:0]       light_ff, light_in;
   logic [IDX_W-1:0] idx_next;
   logic [8:0]       len_total;
   logic             accept;

   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && !q_full;
   assign len_total = {1'b0, req_ch.rx_byte} + 9'(LEN_OVERHEAD);
   assign idx_next = idx_ff + IDX_W'(1);

   // Frame tracking and field capture
   always_comb begin
      phase_in = phase_ff;
      idx_in = idx_ff;
      total_in = total_ff;
      type_in = type_ff;
      class_in = class_ff;
      light_in = light_ff;
      push = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (len_total > 9'(MAX_FRAME)) begin
                  phase_in = PH_HUNT;
                  idx_in = '0;
               end else begin
                  total_in = len_total[IDX_W-1:0];
                  idx_in = IDX_W'(2);
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               if (idx_ff == IDX_W'(POS_TYPE)) type_in = req_ch.rx_byte;
               if (idx_ff == IDX_W'(POS_CLASS)) class_in = req_ch.rx_byte;
               if (idx_ff == IDX_W'(POS_LIGHT)) light_in = req_ch.rx_byte;
               if (idx_next < total_ff && idx_next != '0) begin
                  idx_in = idx_next;
               end else begin
                  phase_in = PH_HUNT;
                  idx_in = '0;
                  push = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (req_ch.rx_byte == START_BYTE) begin
                  phase_in = PH_LEN;
                  idx_in = IDX_W'(1);
                  type_in = '0;
                  class_in = '0;
                  light_in = '0;
               end
            end
         endcase
      end
   end

   // Classified frame end for the grader
   assign push_event.type_light = (type_in == TYPE_LIGHT);
   assign push_event.class_ok = ((class_in[2:0] & CLASS_MASK) == 3'd0);
   assign push_event.light = light_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         idx_ff <= '0;
         total_ff <= '0;
         type_ff <= '0;
         class_ff <= '0;
         light_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff <= idx_in;
         total_ff <= total_in;
         type_ff <= type_in;
         class_ff <= class_in;
         light_ff <= light_in;
      end
   end

endmodule

@@ rtl/core/slb_queue.sv @@
module slb_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  slb_pkg::frame_event_type push_event,
   output logic                     full,
   input  logic                     pop,
   output logic                     q_valid,
   output slb_pkg::frame_event_type q_event
);
   import slb_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_event_type  mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_event = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/core/slb_back.sv @@
module slb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  slb_pkg::csr_write_type   csr_wr,
   input  logic                     q_valid,
   input  slb_pkg::frame_event_type q_event,
   output logic                     pop,
   slb_rsp_if.source                rsp_ch
);
   import slb_pkg::*;

   thresh_array_type thresh_ff;
   logic [7:0]       stored_ff, stored_in;
   logic [2:0]       level_ff, level_in;
   logic             rsp_valid_ff;
   logic [5:0]       mask_ff;
   logic [2:0]       lvl_out_ff;
   logic [7:0]       reading_ff;

   // First threshold the signed reading falls below decides the level
   function automatic logic [2:0] grade(input logic [7:0] raw,
                                        input thresh_array_type th);
      logic signed [8:0] v;
      logic [2:0]        g;
      v = {raw[7], raw};
      priority if (v < $signed({2'b00, th[0]})) g = 3'd1;
      else if (v < $signed({2'b00, th[1]})) g = 3'd2;
      else if (v < $signed({2'b00, th[2]})) g = 3'd3;
      else if (v < $signed({2'b00, th[3]})) g = 3'd4;
      else if (v < $signed({2'b00, th[4]})) g = 3'd5;
      else if (v < $signed({2'b00, th[5]})) g = 3'd6;
      else g = 3'd7;
      return g;
   endfunction

   assign pop = q_valid && (!rsp_valid_ff || rsp_ch.ready);

   // Light update and grading for the popped frame
   always_comb begin
      stored_in = stored_ff;
      level_in = level_ff;
      if (q_event.type_light) begin
         if (q_event.class_ok) stored_in = q_event.light;
         level_in = grade(stored_in, thresh_ff);
      end
   end

   // Threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr.we) begin
         unique case (csr_wr.index)
            CSR_THRESH_ONE:   thresh_ff[0] <= csr_wr.data;
            CSR_THRESH_TWO:   thresh_ff[1] <= csr_wr.data;
            CSR_THRESH_THREE: thresh_ff[2] <= csr_wr.data;
            CSR_THRESH_FOUR:  thresh_ff[3] <= csr_wr.data;
            CSR_THRESH_FIVE:  thresh_ff[4] <= csr_wr.data;
            CSR_THRESH_SIX:   thresh_ff[5] <= csr_wr.data;
            default: ;
         endcase
      end
   end

   // Display state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         level_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            stored_ff <= stored_in;
            level_ff <= level_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mask_ff <= bar_mask(level_in);
         lvl_out_ff <= level_in;
         reading_ff <= stored_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.led_mask = mask_ff;
   assign rsp_ch.light_level = lvl_out_ff;
   assign rsp_ch.light_reading = $signed(reading_ff);

endmodule
